// ===== rtl/ptm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types and constants for the prefix table matcher: table sizes,
// channel payload structs, the queued work item and the result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ptm_pkg;

  localparam int NUM_ENTRIES = 128;
  localparam int MAX_LEN     = 16;

  localparam int IDX_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W      = $clog2(NUM_ENTRIES + 1);
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int CHAR_DEPTH = NUM_ENTRIES * MAX_LEN;
  localparam int CADDR_W    = (CHAR_DEPTH > 1) ? $clog2(CHAR_DEPTH) : 1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  localparam logic       KIND_LOAD   = 1'b0;
  localparam logic       KIND_QUERY  = 1'b1;

  localparam logic [1:0] MK_NONE     = 2'd0;
  localparam logic [1:0] MK_PARTIAL  = 2'd1;
  localparam logic [1:0] MK_EXACT    = 2'd2;

  localparam logic [1:0] LS_ADDED    = 2'd0;
  localparam logic [1:0] LS_FULL     = 2'd1;
  localparam logic [1:0] LS_TOO_LONG = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic       empty_req;
    logic       last;
    logic [7:0] action;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] match_kind;
    logic [7:0] action_out;
    logic [1:0] load_status;
  } out_item_t;

  // Classified item as it travels from the front end to the engine.
  typedef struct packed {
    op_e        op;
    logic       has_char;
    logic       last;
    logic [7:0] char_code;
    logic [7:0] action;
  } work_t;

endpackage

`default_nettype wire

// ===== rtl/prefix_table_matcher.sv =====
// ----------------------------------------------------------------------------
// prefix_table_matcher
// Multi-string prefix matcher: loads pattern entries with action codes and
// answers queries with exact, partial or no match.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   in_       input       in_valid / in_ready    in_data  (in_item_t)
//   out_      output      out_valid / out_ready  out_data (out_item_t)
//
// A load item is handled in the cycle it is taken. A query item that carries
// a character or ends the query enters a sweep over all entry_count stored
// entries, up to NUM_ENTRIES, and the engine reads one stored entry per
// cycle from its registered memories.
// Reset is synchronous and needs no clearing pass; table memories hold
// garbage until loaded. A stalled result only holds the engine; the input
// register and the two-item queue keep taking items meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_table_matcher import ptm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic  fe_valid, fe_ready;
  work_t fe_item;
  logic  q_valid, q_ready;
  work_t q_item;

  ptm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_item  (fe_item)
  );

  ptm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_item  (fe_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  ptm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // The input register is empty right after reset.
  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // The queue cannot report empty and full at once.
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(!q_valid && !fe_ready))
    else $error("queue empty and full together");

  // The engine takes work only when its result register has room.
  a_pop_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready) |-> (!out_valid || out_ready))
    else $error("work taken while result register blocked");
`endif

endmodule

`default_nettype wire

// ===== rtl/ptm_front.sv =====
// ----------------------------------------------------------------------------
// ptm_front
// Input stage: accepts items, classifies them into load or query work and
// drops items that end nothing and carry no character.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_front import ptm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     wr_valid,
  input  logic     wr_ready,
  output work_t    wr_item
);

  logic  vld_r, vld_nxt;
  work_t item_r;
  work_t item_nxt;
  logic  keep;

  // An empty item that does not end the string has no effect anywhere.
  assign keep     = !in_data.empty_req || in_data.last;
  assign in_ready = !vld_r || wr_ready;
  assign wr_valid = vld_r;
  assign wr_item  = item_r;

  always_comb begin
    item_nxt.op        = op_e'(in_data.cmd);
    item_nxt.has_char  = !in_data.empty_req;
    item_nxt.last      = in_data.last;
    item_nxt.char_code = in_data.char_code;
    item_nxt.action    = in_data.action;
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptm_queue.sv =====
// ----------------------------------------------------------------------------
// ptm_queue
// Short FIFO of classified work items between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_queue import ptm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  work_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output work_t rd_item
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  work_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              push, pop;

  assign wr_ready = fill_r != FILL_W'(QUEUE_DEPTH);
  assign rd_valid = fill_r != '0;
  assign rd_item  = slot_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptm_back.sv =====
// ----------------------------------------------------------------------------
// ptm_back
// Table engine: stores entries from load work and sweeps the stored entries
// once per query item, one entry per cycle, and posts a result at the end of each load or query.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_back import ptm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  work_t     q_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic {
    S_IDLE,
    S_SWEEP
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [LEN_W-1:0]     lpos_r, lpos_nxt;
  logic                 too_long_r, too_long_nxt;
  logic [LEN_W-1:0]     qpos_r, qpos_nxt;
  logic [NUM_ENTRIES-1:0] still_r, still_nxt;
  logic [CNT_W-1:0]     issue_r, issue_nxt;
  logic                 pv_r, pv_nxt;
  logic                 found_r, found_nxt;
  logic                 partial_r, partial_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  work_t                cur_r;
  logic [IDX_W-1:0]     pidx_r;
  logic [7:0]           fact_r;

  logic [7:0]           char_mem_r [CHAR_DEPTH];
  logic [LEN_W-1:0]     len_mem_r  [NUM_ENTRIES];
  logic [7:0]           act_mem_r  [NUM_ENTRIES];
  logic [7:0]           char_q_r;
  logic [LEN_W-1:0]     len_q_r;
  logic [7:0]           act_q_r;

  logic                 slot_free, pop, is_load;
  logic                 table_full, lpos_full, too_long_eff, load_add;
  logic [1:0]           ld_status;
  logic [IDX_W-1:0]     count_idx, issue_idx;
  logic                 chr_we;
  logic [CADDR_W-1:0]   chr_waddr, chr_raddr;
  logic [LEN_W-1:0]     new_len;
  logic                 issuing, sm, fail, sm_new, first_hit;
  logic [LEN_W-1:0]     qn;
  logic [1:0]           mk;

  // A work item is taken only when the result register is free or emptying,
  // so a result produced by this item always finds room.
  assign slot_free = !out_valid_r || out_ready;
  assign q_ready   = (state_r == S_IDLE) && slot_free;
  assign pop       = q_valid && q_ready;
  assign is_load   = pop && (q_item.op == OP_LOAD);

  assign count_idx    = count_r[IDX_W-1:0];
  assign table_full   = count_r == CNT_W'(NUM_ENTRIES);
  assign lpos_full    = lpos_r == LEN_W'(MAX_LEN);
  assign too_long_eff = too_long_r || (q_item.has_char && lpos_full);
  assign load_add     = is_load && q_item.last && !table_full && !too_long_eff;
  assign new_len      = q_item.has_char ? lpos_r + 1'b1 : lpos_r;

  always_comb begin
    if (table_full) begin
      ld_status = LS_FULL;
    end else if (too_long_eff) begin
      ld_status = LS_TOO_LONG;
    end else begin
      ld_status = LS_ADDED;
    end
  end

  assign chr_we    = is_load && q_item.has_char && !lpos_full && !table_full;
  assign chr_waddr = CADDR_W'(count_idx * MAX_LEN + lpos_r);

  assign issuing   = (state_r == S_SWEEP) && (issue_r < count_r);
  assign issue_idx = issue_r[IDX_W-1:0];
  assign chr_raddr = CADDR_W'(issue_idx * MAX_LEN + qpos_r);

  // Compare stage on the registered memory read of entry pidx_r.
  assign sm     = still_r[pidx_r];
  assign fail   = (qpos_r >= len_q_r) || (char_q_r != cur_r.char_code);
  assign sm_new = cur_r.has_char ? (sm && !fail) : sm;
  assign qn     = (cur_r.has_char && (qpos_r != LEN_W'(MAX_LEN))) ? qpos_r + 1'b1 : qpos_r;
  assign first_hit = pv_r && cur_r.last && sm_new && !found_r && (len_q_r == qn);

  always_comb begin
    if (found_r) begin
      mk = MK_EXACT;
    end else if (partial_r) begin
      mk = MK_PARTIAL;
    end else begin
      mk = MK_NONE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lpos_nxt      = lpos_r;
    too_long_nxt  = too_long_r;
    qpos_nxt      = qpos_r;
    still_nxt     = still_r;
    issue_nxt     = issue_r;
    pv_nxt        = 1'b0;
    found_nxt     = found_r;
    partial_nxt   = partial_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop && (q_item.op == OP_LOAD)) begin
          if (q_item.has_char && !lpos_full) begin
            lpos_nxt = lpos_r + 1'b1;
          end
          if (q_item.has_char && lpos_full) begin
            too_long_nxt = 1'b1;
          end
          if (q_item.last) begin
            lpos_nxt      = '0;
            too_long_nxt  = 1'b0;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: KIND_LOAD, match_kind: MK_NONE,
                              action_out: 8'd0, load_status: ld_status};
            if (load_add) begin
              // A new entry joins a query only if no query character came yet.
              still_nxt[count_idx] = (qpos_r == '0);
              count_nxt            = count_r + 1'b1;
            end
          end
        end else if (pop) begin
          issue_nxt   = '0;
          found_nxt   = 1'b0;
          partial_nxt = 1'b0;
          state_nxt   = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (issuing) begin
          issue_nxt = issue_r + 1'b1;
          pv_nxt    = 1'b1;
        end
        if (pv_r) begin
          still_nxt[pidx_r] = sm_new;
          if (cur_r.last && sm_new && !found_r) begin
            if (len_q_r == qn) begin
              found_nxt = 1'b1;
            end else if (len_q_r > qn) begin
              partial_nxt = 1'b1;
            end
          end
        end
        if (!issuing && !pv_r) begin
          qpos_nxt  = qn;
          state_nxt = S_IDLE;
          if (cur_r.last) begin
            qpos_nxt      = '0;
            still_nxt     = '1;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: KIND_QUERY, match_kind: mk,
                              action_out: found_r ? fact_r : 8'd0,
                              load_status: LS_ADDED};
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lpos_r      <= '0;
      too_long_r  <= 1'b0;
      qpos_r      <= '0;
      still_r     <= '1;
      issue_r     <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      partial_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lpos_r      <= lpos_nxt;
      too_long_r  <= too_long_nxt;
      qpos_r      <= qpos_nxt;
      still_r     <= still_nxt;
      issue_r     <= issue_nxt;
      pv_r        <= pv_nxt;
      found_r     <= found_nxt;
      partial_r   <= partial_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_item;
    end
    pidx_r <= issue_idx;
    if (first_hit) begin
      fact_r <= act_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (chr_we) begin
      char_mem_r[chr_waddr] <= q_item.char_code;
    end
    char_q_r <= char_mem_r[chr_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_add) begin
      len_mem_r[count_idx] <= new_len;
      act_mem_r[count_idx] <= q_item.action;
    end
    len_q_r <= len_mem_r[issue_idx];
    act_q_r <= act_mem_r[issue_idx];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
